// ===== design/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int NUM_STAGES = 6;

	// Input and result payloads
	typedef struct packed {
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Per-stage load enables, bit 0 is stage 1
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctrl_t;

	// Hue sectors
	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	localparam logic [6:0]  PCT_MAX   = 7'd100;
	localparam logic [8:0]  HUE_LIMIT = 9'd360;
	localparam logic [5:0]  DEG_SPAN  = 6'd60;
	localparam logic [12:0] FRAC_BASE = 13'd6000;

	// floor(n*255/D) ~ (n*MUL) >> SH, low by at most one
	localparam logic [10:0] MUL_P = 11'd1671;
	localparam logic [8:0]  MUL_Q = 9'd445;
	localparam logic [9:0]  MUL_V = 10'd652;
	localparam int          SH_P  = 16;
	localparam int          SH_Q  = 20;
	localparam int          SH_V  = 8;

	localparam logic [27:0] DIV_P = 28'd10000;
	localparam logic [27:0] DIV_Q = 28'd600000;
	localparam logic [27:0] DIV_V = 28'd100;

	// Output of the front stages
	typedef struct packed {
		logic [2:0]  sector;
		logic        black;
		logic [6:0]  val;
		logic [6:0]  np;
		logic [12:0] nq;
		logic [12:0] nt;
	} prep_t;

	// One level: estimate plus the operands of its correction compare
	typedef struct packed {
		logic [7:0]  q0;
		logic [27:0] prod;
		logic [27:0] lim;
	} lane_t;

	typedef struct packed {
		logic [2:0] sector;
		logic       black;
		lane_t      p;
		lane_t      q;
		lane_t      t;
		lane_t      v;
	} scale_t;

endpackage

// ===== design/hsv_to_rgb_convert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_core
// HSV to RGB pixel converter, six-stage pipeline, one pixel per clock while rgb_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   hsv / hsv_valid / hsv_ready carry input requests (hue in degrees,
//   saturation and brightness in percent); rgb / rgb_valid / rgb_ready
//   carry results. A request moves on a clock edge with valid and ready high.
//   Throughput is one pixel per cycle while rgb_ready stays high, set by the
//   six register stages that each take a new pixel every clock unless
//   stalled (clamp and sector, fraction factors, numerator multiplies,
//   reciprocal estimate, correction operands, final routing).
//   Hue of 360 or more gives black; percentages above 100 clamp to 100.
//   Reset empties the pipeline; no state survives between pixels.
//   When the receiver stalls, the last stage holds its result and each stage
//   holds only once the one after it is full, so bubbles still fill and
//   hsv_ready drops only with all six stages occupied.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_core (
	input  logic              clk,
	input  logic              arst_n,
	input  hsv2rgb_pkg::hsv_t hsv,
	input  logic              hsv_valid,
	output logic              hsv_ready,
	output hsv2rgb_pkg::rgb_t rgb,
	output logic              rgb_valid,
	input  logic              rgb_ready
);

	localparam int LAST = hsv2rgb_pkg::NUM_STAGES - 1;

	logic [LAST:0]           stage_valid_q;
	hsv2rgb_pkg::pipe_ctrl_t ctrl;
	hsv2rgb_pkg::prep_t      prep;
	hsv2rgb_pkg::scale_t     scale;

	// a stage loads when it is empty or the stage after it advances
	always_comb begin
		ctrl.en[LAST] = !stage_valid_q[LAST] || rgb_ready;
		for (int i = LAST - 1; i >= 0; i--) begin
			ctrl.en[i] = !stage_valid_q[i] || ctrl.en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (ctrl.en[0]) begin
				stage_valid_q[0] <= hsv_valid;
			end
			for (int i = 1; i <= LAST; i++) begin
				if (ctrl.en[i]) begin
					stage_valid_q[i] <= stage_valid_q[i-1];
				end
			end
		end
	end

	assign hsv_ready = ctrl.en[0];
	assign rgb_valid = stage_valid_q[LAST];

	hsv2rgb_prep u_prep (
		.clk  (clk),
		.ctrl (ctrl),
		.hsv  (hsv),
		.prep (prep)
	);

	hsv2rgb_scale u_scale (
		.clk   (clk),
		.ctrl  (ctrl),
		.prep  (prep),
		.scale (scale)
	);

	hsv2rgb_route u_route (
		.clk   (clk),
		.ctrl  (ctrl),
		.scale (scale),
		.rgb   (rgb)
	);

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&stage_valid_q && !rgb_ready) |-> !hsv_ready)
		else $error("input taken while pipeline full and stalled");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_valid_q != '1) |-> hsv_ready)
		else $error("input refused while pipeline has a bubble");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rgb_valid) |-> $past(stage_valid_q[LAST-1]))
		else $error("result appeared without an item in stage five");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rgb_valid && !rgb_ready) |=> (rgb_valid && $stable(rgb)))
		else $error("stalled result changed");

endmodule

// ===== design/hsv2rgb_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_prep
// Stages 1 and 2: clamp, hue sector and remainder, fraction factors.
// ----------------------------------------------------------------------------
module hsv2rgb_prep (
	input  logic                    clk,
	input  hsv2rgb_pkg::pipe_ctrl_t ctrl,
	input  hsv2rgb_pkg::hsv_t       hsv,
	output hsv2rgb_pkg::prep_t      prep
);

	logic [6:0] sat_c;
	logic [6:0] val_c;
	logic [2:0] sec;
	logic [8:0] base;
	logic       black;
	logic [5:0] rem;

	logic [2:0] sector_s1;
	logic       black_s1;
	logic [5:0] rem_s1;
	logic [6:0] sat_s1;
	logic [6:0] val_s1;

	logic [12:0] rs;
	logic [12:0] trs;

	always_comb begin
		sat_c = (hsv.saturation > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX
			: hsv.saturation;
		val_c = (hsv.brightness > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX
			: hsv.brightness;
		black = (hsv.hue >= hsv2rgb_pkg::HUE_LIMIT);
		priority if (hsv.hue < 9'd60) begin
			sec  = hsv2rgb_pkg::SEC_RY;
			base = 9'd0;
		end else if (hsv.hue < 9'd120) begin
			sec  = hsv2rgb_pkg::SEC_YG;
			base = 9'd60;
		end else if (hsv.hue < 9'd180) begin
			sec  = hsv2rgb_pkg::SEC_GC;
			base = 9'd120;
		end else if (hsv.hue < 9'd240) begin
			sec  = hsv2rgb_pkg::SEC_CB;
			base = 9'd180;
		end else if (hsv.hue < 9'd300) begin
			sec  = hsv2rgb_pkg::SEC_BM;
			base = 9'd240;
		end else begin
			sec  = hsv2rgb_pkg::SEC_MR;
			base = 9'd300;
		end
		// out-of-range hue: keep the remainder sane, result is forced black later
		rem = black ? 6'd0 : 6'(hsv.hue - base);
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			sector_s1 <= sec;
			black_s1  <= black;
			rem_s1    <= rem;
			sat_s1    <= sat_c;
			val_s1    <= val_c;
		end
	end

	assign rs  = 13'(rem_s1) * 13'(sat_s1);
	assign trs = 13'(hsv2rgb_pkg::DEG_SPAN - rem_s1) * 13'(sat_s1);

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			prep.sector <= sector_s1;
			prep.black  <= black_s1;
			prep.val    <= val_s1;
			prep.np     <= hsv2rgb_pkg::PCT_MAX - sat_s1;
			prep.nq     <= hsv2rgb_pkg::FRAC_BASE - rs;
			prep.nt     <= hsv2rgb_pkg::FRAC_BASE - trs;
		end
	end

endmodule

// ===== design/hsv2rgb_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Stages 3 to 5: level numerators, reciprocal estimate, correction operands.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
	input  logic                    clk,
	input  hsv2rgb_pkg::pipe_ctrl_t ctrl,
	input  hsv2rgb_pkg::prep_t      prep,
	output hsv2rgb_pkg::scale_t     scale
);

	logic [2:0]  sector_s3;
	logic        black_s3;
	logic [13:0] np_s3;
	logic [19:0] nq_s3;
	logic [19:0] nt_s3;
	logic [6:0]  nv_s3;

	logic [24:0] ep;
	logic [28:0] eq;
	logic [28:0] et;
	logic [16:0] ev;

	logic [2:0]  sector_s4;
	logic        black_s4;
	logic [13:0] np_s4;
	logic [19:0] nq_s4;
	logic [19:0] nt_s4;
	logic [6:0]  nv_s4;
	logic [7:0]  qp_s4;
	logic [7:0]  qq_s4;
	logic [7:0]  qt_s4;
	logic [7:0]  qv_s4;

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			sector_s3 <= prep.sector;
			black_s3  <= prep.black;
			np_s3     <= 14'(prep.val) * 14'(prep.np);
			nq_s3     <= 20'(prep.val) * 20'(prep.nq);
			nt_s3     <= 20'(prep.val) * 20'(prep.nt);
			nv_s3     <= prep.val;
		end
	end

	assign ep = 25'(np_s3) * 25'(hsv2rgb_pkg::MUL_P);
	assign eq = 29'(nq_s3) * 29'(hsv2rgb_pkg::MUL_Q);
	assign et = 29'(nt_s3) * 29'(hsv2rgb_pkg::MUL_Q);
	assign ev = 17'(nv_s3) * 17'(hsv2rgb_pkg::MUL_V);

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			sector_s4 <= sector_s3;
			black_s4  <= black_s3;
			np_s4     <= np_s3;
			nq_s4     <= nq_s3;
			nt_s4     <= nt_s3;
			nv_s4     <= nv_s3;
			qp_s4     <= ep[hsv2rgb_pkg::SH_P+7:hsv2rgb_pkg::SH_P];
			qq_s4     <= eq[hsv2rgb_pkg::SH_Q+7:hsv2rgb_pkg::SH_Q];
			qt_s4     <= et[hsv2rgb_pkg::SH_Q+7:hsv2rgb_pkg::SH_Q];
			qv_s4     <= ev[hsv2rgb_pkg::SH_V+7:hsv2rgb_pkg::SH_V];
		end
	end

	// prod = n*255; lim = (q0+1)*D; the estimate is one low when prod >= lim
	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			scale.sector <= sector_s4;
			scale.black  <= black_s4;
			scale.p.q0   <= qp_s4;
			scale.p.prod <= (28'(np_s4) << 8) - 28'(np_s4);
			scale.p.lim  <= 28'({1'b0, qp_s4} + 9'd1) * hsv2rgb_pkg::DIV_P;
			scale.q.q0   <= qq_s4;
			scale.q.prod <= (28'(nq_s4) << 8) - 28'(nq_s4);
			scale.q.lim  <= 28'({1'b0, qq_s4} + 9'd1) * hsv2rgb_pkg::DIV_Q;
			scale.t.q0   <= qt_s4;
			scale.t.prod <= (28'(nt_s4) << 8) - 28'(nt_s4);
			scale.t.lim  <= 28'({1'b0, qt_s4} + 9'd1) * hsv2rgb_pkg::DIV_Q;
			scale.v.q0   <= qv_s4;
			scale.v.prod <= (28'(nv_s4) << 8) - 28'(nv_s4);
			scale.v.lim  <= 28'({1'b0, qv_s4} + 9'd1) * hsv2rgb_pkg::DIV_V;
		end
	end

endmodule

// ===== design/hsv2rgb_route.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_route
// Stage 6: finish the levels and route them to the channels by sector.
// ----------------------------------------------------------------------------
module hsv2rgb_route (
	input  logic                    clk,
	input  hsv2rgb_pkg::pipe_ctrl_t ctrl,
	input  hsv2rgb_pkg::scale_t     scale,
	output hsv2rgb_pkg::rgb_t       rgb
);

	logic [7:0]        lp;
	logic [7:0]        lq;
	logic [7:0]        lt;
	logic [7:0]        lv;
	hsv2rgb_pkg::rgb_t pix;

	assign lp = scale.p.q0 + 8'(scale.p.prod >= scale.p.lim);
	assign lq = scale.q.q0 + 8'(scale.q.prod >= scale.q.lim);
	assign lt = scale.t.q0 + 8'(scale.t.prod >= scale.t.lim);
	assign lv = scale.v.q0 + 8'(scale.v.prod >= scale.v.lim);

	always_comb begin
		unique case (scale.sector)
			hsv2rgb_pkg::SEC_RY: pix = '{red: lv, green: lt, blue: lp};
			hsv2rgb_pkg::SEC_YG: pix = '{red: lq, green: lv, blue: lp};
			hsv2rgb_pkg::SEC_GC: pix = '{red: lp, green: lv, blue: lt};
			hsv2rgb_pkg::SEC_CB: pix = '{red: lp, green: lq, blue: lv};
			hsv2rgb_pkg::SEC_BM: pix = '{red: lt, green: lp, blue: lv};
			default:             pix = '{red: lv, green: lp, blue: lq};
		endcase
		if (scale.black) begin
			pix = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[5]) begin
			rgb <= pix;
		end
	end

endmodule
